### hdl/pcsf_pkg.sv
// Package for the pancake sort flip sequencer: item structs, datapath
// operation and jump condition codes, and the microprogram table.
// No dependencies; pcsf_seq, pcsf_dp and the top module use this package.
`default_nettype none

package pcsf_pkg;

    // Widths fixed by the item formats.
    localparam int unsigned VALUE_W = 8;
    localparam int unsigned FLIP_W  = 6;
    localparam int unsigned UPC_W   = 5;

    localparam logic [VALUE_W-1:0] MAX_VALUE_RESET = 8'd10;

    // One input item.
    typedef struct packed {
        logic [VALUE_W-1:0] size_value;
        logic               end_of_stack;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [FLIP_W-1:0] flip_position;
        logic              last_result;
        logic              input_error;
    } out_item_t;

    // Operations that the datapath carries out for one microinstruction.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_INIT,
        OP_RD_POS,
        OP_LDBEST,
        OP_RD_J,
        OP_CMP,
        OP_EMIT_BEST,
        OP_RD_LOHI,
        OP_W1,
        OP_W2,
        OP_EMIT_POS,
        OP_DEC_POS,
        OP_EMIT_END
    } dp_op_t;

    // Jump conditions tested by the sequencer.
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_POS_ZERO,
        C_J_NOT_ONE,
        C_BEST_EQ_POS,
        C_BEST_ZERO,
        C_LO_GE_HI
    } cond_t;

    // One control word of the microprogram.
    typedef struct packed {
        dp_op_t           op;
        cond_t            cond;
        logic [UPC_W-1:0] target;
    } ctl_word_t;

    // Status from the datapath back to the sequencer.
    typedef struct packed {
        logic stall;
        logic pos_zero;
        logic j_not_one;
        logic best_eq_pos;
        logic best_zero;
        logic lo_ge_hi;
    } dp_flags_t;

    // Microprogram addresses.
    localparam logic [UPC_W-1:0] UA_LOAD      = 5'd0;
    localparam logic [UPC_W-1:0] UA_INIT      = 5'd1;
    localparam logic [UPC_W-1:0] UA_OUTER     = 5'd2;
    localparam logic [UPC_W-1:0] UA_LDBEST    = 5'd3;
    localparam logic [UPC_W-1:0] UA_SCAN_RD   = 5'd4;
    localparam logic [UPC_W-1:0] UA_SCAN_CMP  = 5'd5;
    localparam logic [UPC_W-1:0] UA_DECIDE    = 5'd6;
    localparam logic [UPC_W-1:0] UA_TOP_CHK   = 5'd7;
    localparam logic [UPC_W-1:0] UA_EMIT_BEST = 5'd8;
    localparam logic [UPC_W-1:0] UA_REVA_RD   = 5'd9;
    localparam logic [UPC_W-1:0] UA_REVA_W1   = 5'd10;
    localparam logic [UPC_W-1:0] UA_REVA_W2   = 5'd11;
    localparam logic [UPC_W-1:0] UA_EMIT_POS  = 5'd12;
    localparam logic [UPC_W-1:0] UA_REVB_RD   = 5'd13;
    localparam logic [UPC_W-1:0] UA_REVB_W1   = 5'd14;
    localparam logic [UPC_W-1:0] UA_REVB_W2   = 5'd15;
    localparam logic [UPC_W-1:0] UA_NEXT      = 5'd16;
    localparam logic [UPC_W-1:0] UA_FINISH    = 5'd17;

    // The microprogram: load, then one outer pass per bottom position with
    // a scan for the largest value and up to two prefix reversals.
    function automatic ctl_word_t mc_rom(input logic [UPC_W-1:0] addr);
        ctl_word_t w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: UA_LOAD};
        case (addr)
            UA_LOAD:      w = '{op: OP_LOAD,      cond: C_NEVER,       target: UA_LOAD};
            UA_INIT:      w = '{op: OP_INIT,      cond: C_NEVER,       target: UA_LOAD};
            UA_OUTER:     w = '{op: OP_RD_POS,    cond: C_POS_ZERO,    target: UA_FINISH};
            UA_LDBEST:    w = '{op: OP_LDBEST,    cond: C_NEVER,       target: UA_LOAD};
            UA_SCAN_RD:   w = '{op: OP_RD_J,      cond: C_NEVER,       target: UA_LOAD};
            UA_SCAN_CMP:  w = '{op: OP_CMP,       cond: C_J_NOT_ONE,   target: UA_SCAN_RD};
            UA_DECIDE:    w = '{op: OP_NOP,       cond: C_BEST_EQ_POS, target: UA_NEXT};
            UA_TOP_CHK:   w = '{op: OP_NOP,       cond: C_BEST_ZERO,   target: UA_EMIT_POS};
            UA_EMIT_BEST: w = '{op: OP_EMIT_BEST, cond: C_NEVER,       target: UA_LOAD};
            UA_REVA_RD:   w = '{op: OP_RD_LOHI,   cond: C_LO_GE_HI,    target: UA_EMIT_POS};
            UA_REVA_W1:   w = '{op: OP_W1,        cond: C_NEVER,       target: UA_LOAD};
            UA_REVA_W2:   w = '{op: OP_W2,        cond: C_ALWAYS,      target: UA_REVA_RD};
            UA_EMIT_POS:  w = '{op: OP_EMIT_POS,  cond: C_NEVER,       target: UA_LOAD};
            UA_REVB_RD:   w = '{op: OP_RD_LOHI,   cond: C_LO_GE_HI,    target: UA_NEXT};
            UA_REVB_W1:   w = '{op: OP_W1,        cond: C_NEVER,       target: UA_LOAD};
            UA_REVB_W2:   w = '{op: OP_W2,        cond: C_ALWAYS,      target: UA_REVB_RD};
            UA_NEXT:      w = '{op: OP_DEC_POS,   cond: C_ALWAYS,      target: UA_OUTER};
            UA_FINISH:    w = '{op: OP_EMIT_END,  cond: C_ALWAYS,      target: UA_LOAD};
            default:      w = '{op: OP_NOP,       cond: C_ALWAYS,      target: UA_LOAD};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### hdl/pcsf_ram.sv
// Generic RAM with one write port and two registered read ports.
// No dependencies.
`default_nettype none

module pcsf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  wire                     aclk,
    input  wire                     we,
    input  wire [$clog2(DEPTH)-1:0] waddr,
    input  wire [WIDTH-1:0]         wdata,
    input  wire [$clog2(DEPTH)-1:0] raddr_a,
    input  wire [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]        rdata_a,
    output logic [WIDTH-1:0]        rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered reads.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

### hdl/pcsf_seq.sv
// Microprogram sequencer: step counter, control table lookup and jumps.
// Depends on pcsf_pkg.
`default_nettype none

module pcsf_seq (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  pcsf_pkg::dp_flags_t  flags,
    output pcsf_pkg::dp_op_t     op
);

    logic [pcsf_pkg::UPC_W-1:0] upc_reg;
    logic [pcsf_pkg::UPC_W-1:0] upc_next;
    pcsf_pkg::ctl_word_t        cw;
    logic                       take;

    // Current control word.
    assign cw = pcsf_pkg::mc_rom(upc_reg);
    assign op = cw.op;

    // Jump condition.
    always_comb begin
        case (cw.cond)
            pcsf_pkg::C_NEVER:       take = 1'b0;
            pcsf_pkg::C_ALWAYS:      take = 1'b1;
            pcsf_pkg::C_POS_ZERO:    take = flags.pos_zero;
            pcsf_pkg::C_J_NOT_ONE:   take = flags.j_not_one;
            pcsf_pkg::C_BEST_EQ_POS: take = flags.best_eq_pos;
            pcsf_pkg::C_BEST_ZERO:   take = flags.best_zero;
            pcsf_pkg::C_LO_GE_HI:    take = flags.lo_ge_hi;
            default:                 take = 1'b0;
        endcase
    end

    // Next step: hold while the datapath stalls, else jump or advance.
    always_comb begin
        if (flags.stall) begin
            upc_next = upc_reg;
        end else if (take) begin
            upc_next = cw.target;
        end else begin
            upc_next = upc_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= pcsf_pkg::UA_LOAD;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

`default_nettype wire

### hdl/pcsf_dp.sv
// Datapath: stack memory, scan and reversal registers, input checks and
// the result register. Depends on pcsf_pkg and pcsf_ram.
`default_nettype none

module pcsf_dp #(
    parameter int unsigned STACK_DEPTH = 32
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  pcsf_pkg::dp_op_t                    op,
    input  wire [pcsf_pkg::VALUE_W-1:0]         max_value,
    output pcsf_pkg::dp_flags_t                 flags,
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  pcsf_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output pcsf_pkg::out_item_t                 m_data
);

    localparam int unsigned IW = $clog2(STACK_DEPTH);
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

    logic [CW-1:0]                cnt_reg, cnt_next;
    logic                         err_reg, err_next;
    logic [IW-1:0]                pos_reg, pos_next;
    logic [IW-1:0]                best_reg, best_next;
    logic [pcsf_pkg::VALUE_W-1:0] bestv_reg, bestv_next;
    logic [IW-1:0]                j_reg, j_next;
    logic [IW-1:0]                lo_reg, lo_next;
    logic [IW-1:0]                hi_reg, hi_next;
    logic [pcsf_pkg::VALUE_W-1:0] tmp_reg, tmp_next;
    logic                         m_valid_reg, m_valid_next;
    pcsf_pkg::out_item_t          m_data_reg, m_data_next;

    logic                         we;
    logic [IW-1:0]                waddr;
    logic [pcsf_pkg::VALUE_W-1:0] wdata;
    logic [IW-1:0]                raddr_a, raddr_b;
    logic [pcsf_pkg::VALUE_W-1:0] rd_a, rd_b;

    logic                         out_free;
    logic                         accept;
    logic                         bad;
    logic                         emit;
    pcsf_pkg::out_item_t          emit_data;
    logic                         stall;

    pcsf_ram #(
        .WIDTH (pcsf_pkg::VALUE_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // Handshake and input checks.
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (op == pcsf_pkg::OP_LOAD) && out_free;
    assign accept   = s_valid && s_ready;
    assign bad      = (s_data.size_value == '0) || (s_data.size_value > max_value)
                      || (cnt_reg >= CW'(STACK_DEPTH));

    // Status flags for the sequencer.
    assign flags.stall       = stall;
    assign flags.pos_zero    = (pos_reg == '0);
    assign flags.j_not_one   = (j_reg != IW'(1));
    assign flags.best_eq_pos = (best_reg == pos_reg);
    assign flags.best_zero   = (best_reg == '0);
    assign flags.lo_ge_hi    = (lo_reg >= hi_reg);

    // Operation decode.
    always_comb begin
        cnt_next   = cnt_reg;
        err_next   = err_reg;
        pos_next   = pos_reg;
        best_next  = best_reg;
        bestv_next = bestv_reg;
        j_next     = j_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        tmp_next   = tmp_reg;
        we         = 1'b0;
        waddr      = lo_reg;
        wdata      = rd_b;
        raddr_a    = lo_reg;
        raddr_b    = hi_reg;
        emit       = 1'b0;
        emit_data  = '{flip_position: '0, last_result: 1'b0, input_error: 1'b0};
        stall      = 1'b0;
        case (op)
            pcsf_pkg::OP_LOAD: begin
                // Hold at this step until a good item marked last is stored.
                stall = 1'b1;
                if (accept) begin
                    if (err_reg) begin
                        if (s_data.end_of_stack) begin
                            err_next = 1'b0;
                        end
                    end else if (bad) begin
                        cnt_next  = '0;
                        err_next  = !s_data.end_of_stack;
                        emit      = 1'b1;
                        emit_data = '{flip_position: '0, last_result: 1'b1,
                                      input_error: 1'b1};
                    end else begin
                        we       = 1'b1;
                        waddr    = cnt_reg[IW-1:0];
                        wdata    = s_data.size_value;
                        cnt_next = cnt_reg + 1'b1;
                        stall    = !s_data.end_of_stack;
                    end
                end
            end
            pcsf_pkg::OP_INIT: begin
                pos_next = IW'(cnt_reg - 1'b1);
            end
            pcsf_pkg::OP_RD_POS: begin
                raddr_a   = pos_reg;
                best_next = pos_reg;
            end
            pcsf_pkg::OP_LDBEST: begin
                bestv_next = rd_a;
                j_next     = pos_reg;
            end
            pcsf_pkg::OP_RD_J: begin
                raddr_a = j_reg - 1'b1;
            end
            pcsf_pkg::OP_CMP: begin
                // Strictly greater keeps the lowest-down copy on ties.
                if (rd_a > bestv_reg) begin
                    best_next  = j_reg - 1'b1;
                    bestv_next = rd_a;
                end
                j_next = j_reg - 1'b1;
            end
            pcsf_pkg::OP_EMIT_BEST: begin
                stall     = !out_free;
                emit      = out_free;
                emit_data = '{flip_position: pcsf_pkg::FLIP_W'(cnt_reg)
                                             - pcsf_pkg::FLIP_W'(best_reg),
                              last_result: 1'b0, input_error: 1'b0};
                lo_next   = '0;
                hi_next   = best_reg;
            end
            pcsf_pkg::OP_RD_LOHI: begin
                raddr_a = lo_reg;
                raddr_b = hi_reg;
            end
            pcsf_pkg::OP_W1: begin
                we       = 1'b1;
                waddr    = lo_reg;
                wdata    = rd_b;
                tmp_next = rd_a;
            end
            pcsf_pkg::OP_W2: begin
                we      = 1'b1;
                waddr   = hi_reg;
                wdata   = tmp_reg;
                lo_next = lo_reg + 1'b1;
                hi_next = hi_reg - 1'b1;
            end
            pcsf_pkg::OP_EMIT_POS: begin
                stall     = !out_free;
                emit      = out_free;
                emit_data = '{flip_position: pcsf_pkg::FLIP_W'(cnt_reg)
                                             - pcsf_pkg::FLIP_W'(pos_reg),
                              last_result: 1'b0, input_error: 1'b0};
                lo_next   = '0;
                hi_next   = pos_reg;
            end
            pcsf_pkg::OP_DEC_POS: begin
                pos_next = pos_reg - 1'b1;
            end
            pcsf_pkg::OP_EMIT_END: begin
                stall     = !out_free;
                emit      = out_free;
                emit_data = '{flip_position: '0, last_result: 1'b1, input_error: 1'b0};
                if (out_free) begin
                    cnt_next = '0;
                end
            end
            default: begin
                stall = 1'b0;
            end
        endcase
    end

    // Result register: one item waits here while the receiver stalls.
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = emit_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            err_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Working registers and result payload.
    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        best_reg   <= best_next;
        bestv_reg  <= bestv_next;
        j_reg      <= j_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        tmp_reg    <= tmp_next;
        m_data_reg <= m_data_next;
    end

endmodule

`default_nettype wire

### hdl/pancake_sort_flip_sequence.sv
// Pancake sort flip sequence.
// Input items load a stack, top first, one item per cycle while the result
// register is free; an item with end_of_stack set closes the stack.
// The stack is then sorted by prefix reversals under control of a small
// microprogram, and each flip leaves as one result item holding its position
// counted from the bottom. A result with position 0 and last_result set ends
// the run. A size of zero, a size above max_value or a full stack gives one
// item with input_error set, valid the cycle after the bad item is taken;
// later items of that stack are dropped silently.
// Closing a stack runs the init, outer check and finish steps; the finish step
// puts the closing result into the result register. Each bottom position p
// (counted from 0, p >= 1) is scanned and kept if it holds its largest value,
// else up to two flips follow, each a result item and a prefix reversal read
// through both read ports and written one place at a time. No input item is
// taken while sorting. A stalled receiver holds the result register and
// freezes the sequencer at its next result step. Reset empties the stack,
// clears the error mark and sets max_value to 10. max_value is to be written
// by the user through cfg_wr_en and cfg_wr_data while idle; the block does
// not enforce this. Depends on pcsf_pkg, pcsf_seq, pcsf_dp and pcsf_ram.
`default_nettype none

module pancake_sort_flip_sequence #(
    parameter int unsigned STACK_DEPTH = 32
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_wr_en,
    input  wire [pcsf_pkg::VALUE_W-1:0]  cfg_wr_data,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  pcsf_pkg::in_item_t           s_data,
    output logic                         m_valid,
    input  wire                          m_ready,
    output pcsf_pkg::out_item_t          m_data
);

    logic [pcsf_pkg::VALUE_W-1:0] max_value_reg;
    pcsf_pkg::dp_op_t             op;
    pcsf_pkg::dp_flags_t          flags;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_value_reg <= pcsf_pkg::MAX_VALUE_RESET;
        end else if (cfg_wr_en) begin
            max_value_reg <= cfg_wr_data;
        end
    end

    pcsf_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .op      (op)
    );

    pcsf_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op        (op),
        .max_value (max_value_reg),
        .flags     (flags),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire
